// ===== rtl/core/olist_pkg.sv =====
// ----------------------------------------------------------------------------
// olist_pkg
// Shared constants, codes and types of the ordered list engine.
// ----------------------------------------------------------------------------
`default_nettype none

package olist_pkg;

  localparam int CAPACITY    = 16;
  localparam int VALUE_WIDTH = 32;

  localparam int IDX_W  = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int MODE_W = 4;
  localparam int IVAL_W = 32;
  localparam int POS_W  = 5;
  localparam int STAT_W = 2;
  localparam int RVAL_W = 32;

  localparam int S_TDATA_W = ((IVAL_W + POS_W + 7) / 8) * 8;
  localparam int M_TDATA_W = ((POS_W + POS_W + RVAL_W + 7) / 8) * 8;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH_FRONT  = 4'd0,
    MODE_PUSH_BACK   = 4'd1,
    MODE_INS_AFTER   = 4'd2,
    MODE_INS_BEFORE  = 4'd3,
    MODE_FIND_FIRST  = 4'd4,
    MODE_FIND_LAST   = 4'd5,
    MODE_RM_FIRST    = 4'd6,
    MODE_RM_LAST     = 4'd7,
    MODE_DUMP_FWD    = 4'd8,
    MODE_DUMP_REV    = 4'd9,
    MODE_CLEAR       = 4'd10
  } mode_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK   = 2'd0,
    STAT_MISS = 2'd1,
    STAT_FULL = 2'd2
  } status_e;

  typedef enum logic {
    ST_IDLE,
    ST_DUMP
  } state_e;

  typedef struct packed {
    logic [VALUE_WIDTH-1:0] key;
    logic [CNT_W-1:0]       count;
    logic                   ins;
    logic [IDX_W-1:0]       ins_idx;
    logic                   rm_first;
    logic                   rm_last;
  } cell_ctl_t;

  typedef struct packed {
    status_e          status;
    logic [POS_W-1:0] found_pos;
    logic [POS_W-1:0] length;
    logic [RVAL_W-1:0] value;
    logic             last;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/olist_cell.sv =====
// ----------------------------------------------------------------------------
// olist_cell
// One list element: holds a value, compares it with the key and shifts
// toward either neighbor on insert and remove.
// ----------------------------------------------------------------------------
`default_nettype none

module olist_cell (
  input  wire logic                            clk_i,
  input  wire olist_pkg::cell_ctl_t            ctl_i,
  input  wire logic [olist_pkg::IDX_W-1:0]       idx_i,
  input  wire logic [olist_pkg::VALUE_WIDTH-1:0] left_val_i,
  input  wire logic [olist_pkg::VALUE_WIDTH-1:0] right_val_i,
  input  wire logic                            front_any_i,
  input  wire logic                            back_any_i,
  output logic      [olist_pkg::VALUE_WIDTH-1:0] val_o,
  output logic                                 match_o,
  output logic                                 front_any_o,
  output logic                                 back_any_o
);
  import olist_pkg::*;

  logic [VALUE_WIDTH-1:0] val_q, val_d;
  logic                   valid;

  assign valid       = CNT_W'(idx_i) < ctl_i.count;
  assign match_o     = valid && (val_q == ctl_i.key);
  assign front_any_o = front_any_i | match_o;
  assign back_any_o  = back_any_i | match_o;
  assign val_o       = val_q;

  always_comb begin
    val_d = val_q;
    if (ctl_i.ins) begin
      if (idx_i > ctl_i.ins_idx) begin
        val_d = left_val_i;
      end else if (idx_i == ctl_i.ins_idx) begin
        val_d = ctl_i.key;
      end
    end else if (ctl_i.rm_first) begin
      if (front_any_o) begin
        val_d = right_val_i;
      end
    end else if (ctl_i.rm_last) begin
      if (!back_any_i) begin
        val_d = right_val_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

`default_nettype wire

// ===== rtl/core/olist_ctrl.sv =====
// ----------------------------------------------------------------------------
// olist_ctrl
// Request decode, element count, dump sequencer and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module olist_ctrl (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          req_valid_i,
  output logic                               req_ready_o,
  input  wire logic [olist_pkg::MODE_W-1:0]  req_mode_i,
  input  wire logic [olist_pkg::IVAL_W-1:0]  req_value_i,
  input  wire logic [olist_pkg::POS_W-1:0]   req_pos_i,
  input  wire logic [olist_pkg::CAPACITY-1:0] match_i,
  input  wire logic [olist_pkg::CAPACITY-1:0] front_any_i,
  input  wire logic [olist_pkg::CAPACITY-1:0] back_any_i,
  input  wire logic [olist_pkg::CAPACITY-1:0][olist_pkg::VALUE_WIDTH-1:0] vals_i,
  output olist_pkg::cell_ctl_t               ctl_o,
  output logic                               res_valid_o,
  input  wire logic                          res_ready_i,
  output olist_pkg::result_t                 res_o
);
  import olist_pkg::*;

  localparam int CMP_W = POS_W + CNT_W;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] dump_pos_q, dump_pos_d;
  logic             dump_rev_q, dump_rev_d;
  logic             res_valid_q, res_valid_d;
  result_t          res_q, res_d;

  logic                    out_free, acc, full, bad_pos, found, dump_last;
  logic [CNT_W-1:0]        first_pos, last_pos, hit_pos, dump_idx_w;
  logic [IDX_W-1:0]        dump_idx;
  logic signed [IVAL_W-1:0] ival;
  mode_e                   mode;

  assign out_free    = !res_valid_q || res_ready_i;
  assign req_ready_o = (state_q == ST_IDLE) && out_free;
  assign acc         = req_valid_i && req_ready_o;
  assign mode        = mode_e'(req_mode_i);
  assign ival        = signed'(req_value_i);
  assign full        = count_q == CNT_W'(CAPACITY);
  assign bad_pos     = (req_pos_i == '0) || (CMP_W'(req_pos_i) > CMP_W'(count_q));
  assign found       = front_any_i[CAPACITY-1] | match_i[CAPACITY-1];
  assign dump_idx_w  = dump_pos_q - CNT_W'(1);
  assign dump_idx    = dump_idx_w[IDX_W-1:0];
  assign dump_last   = dump_rev_q ? (dump_pos_q == CNT_W'(1)) : (dump_pos_q == count_q);

  always_comb begin
    first_pos = '0;
    last_pos  = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (match_i[i] && !front_any_i[i]) first_pos = first_pos | CNT_W'(i + 1);
      if (match_i[i] && !back_any_i[i])  last_pos  = last_pos  | CNT_W'(i + 1);
    end
  end

  assign hit_pos = (mode == MODE_FIND_LAST || mode == MODE_RM_LAST) ? last_pos : first_pos;

  // next state
  always_comb begin
    state_d    = state_q;
    dump_pos_d = dump_pos_q;
    dump_rev_d = dump_rev_q;
    case (state_q)
      ST_IDLE: begin
        if (acc && (mode == MODE_DUMP_FWD || mode == MODE_DUMP_REV) && count_q != '0) begin
          state_d    = ST_DUMP;
          dump_rev_d = mode == MODE_DUMP_REV;
          dump_pos_d = (mode == MODE_DUMP_REV) ? count_q : CNT_W'(1);
        end
      end
      ST_DUMP: begin
        if (out_free) begin
          dump_pos_d = dump_rev_q ? dump_pos_q - CNT_W'(1) : dump_pos_q + CNT_W'(1);
          if (dump_last) state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctl_o          = '0;
    ctl_o.key      = VALUE_WIDTH'(ival);
    ctl_o.count    = count_q;
    count_d        = count_q;
    res_valid_d    = res_valid_q && !res_ready_i;
    res_d          = res_q;
    if (state_q == ST_DUMP) begin
      if (out_free) begin
        res_valid_d     = 1'b1;
        res_d.status    = STAT_OK;
        res_d.found_pos = POS_W'(dump_pos_q);
        res_d.length    = POS_W'(count_q);
        res_d.value     = RVAL_W'(vals_i[dump_idx]);
        res_d.last      = dump_last;
      end
    end else if (acc) begin
      res_d.status    = STAT_OK;
      res_d.found_pos = '0;
      res_d.value     = '0;
      res_d.last      = 1'b1;
      res_valid_d     = 1'b1;
      case (mode)
        MODE_PUSH_FRONT, MODE_PUSH_BACK, MODE_INS_AFTER, MODE_INS_BEFORE: begin
          if (full) begin
            res_d.status = STAT_FULL;
          end else if ((mode == MODE_INS_AFTER || mode == MODE_INS_BEFORE) && bad_pos) begin
            res_d.status = STAT_MISS;
          end else begin
            ctl_o.ins = 1'b1;
            count_d   = count_q + CNT_W'(1);
            case (mode)
              MODE_PUSH_FRONT: ctl_o.ins_idx = '0;
              MODE_PUSH_BACK:  ctl_o.ins_idx = IDX_W'(count_q);
              MODE_INS_AFTER:  ctl_o.ins_idx = IDX_W'(req_pos_i);
              default:         ctl_o.ins_idx = IDX_W'(req_pos_i - POS_W'(1));
            endcase
          end
        end
        MODE_FIND_FIRST, MODE_FIND_LAST: begin
          res_d.status    = found ? STAT_OK : STAT_MISS;
          res_d.found_pos = POS_W'(hit_pos);
        end
        MODE_RM_FIRST, MODE_RM_LAST: begin
          res_d.status    = found ? STAT_OK : STAT_MISS;
          res_d.found_pos = POS_W'(hit_pos);
          if (found) begin
            ctl_o.rm_first = mode == MODE_RM_FIRST;
            ctl_o.rm_last  = mode == MODE_RM_LAST;
            count_d        = count_q - CNT_W'(1);
          end
        end
        MODE_DUMP_FWD, MODE_DUMP_REV: begin
          if (count_q == '0) begin
            res_d.status = STAT_MISS;
          end else begin
            res_valid_d = 1'b0;
          end
        end
        MODE_CLEAR: count_d = '0;
        default:    res_d.status = STAT_MISS;
      endcase
      res_d.length = POS_W'(count_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q      <= res_d;
    dump_pos_q <= dump_pos_d;
    dump_rev_q <= dump_rev_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

// ===== rtl/core/ordered_list_engine.sv =====
// An edit, find or clear result is registered and valid in the cycle after its transfer.
// Throughput: 1 request per cycle while results are taken and no dump runs; the result register
// frees the input as soon as its content is taken.
// Dump: the transfer starts the dump state, which loads the first element into the result
// register; then 1 element per cycle while results are taken, set by the single read port of the cell row.
// Reset: count clears, output goes idle; cell contents stay undefined.
// ----------------------------------------------------------------------------
// ordered_list_engine
// Bounded ordered list held in a row of shifting compare cells.
// ----------------------------------------------------------------------------
`default_nettype none

module ordered_list_engine (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  // item_value, position
  input  wire logic [olist_pkg::S_TDATA_W-1:0]  s_axis_tdata_i,
  // mode
  input  wire logic [olist_pkg::MODE_W-1:0]     s_axis_tuser_i,
  output logic                                  m_axis_tvalid_o,
  input  wire logic                             m_axis_tready_i,
  // found_position, list_length, read_value
  output logic      [olist_pkg::M_TDATA_W-1:0]  m_axis_tdata_o,
  // status
  output logic      [olist_pkg::STAT_W-1:0]     m_axis_tuser_o,
  output logic                                  m_axis_tlast_o
);
  import olist_pkg::*;

  cell_ctl_t                               ctl;
  result_t                                 res;
  logic [CAPACITY-1:0][VALUE_WIDTH-1:0]    vals;
  logic [CAPACITY-1:0]                     match, front_in, back_in, front_out, back_out;

  olist_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid_i),
    .req_ready_o (s_axis_tready_o),
    .req_mode_i  (s_axis_tuser_i),
    .req_value_i (s_axis_tdata_i[IVAL_W-1:0]),
    .req_pos_i   (s_axis_tdata_i[IVAL_W+POS_W-1:IVAL_W]),
    .match_i     (match),
    .front_any_i (front_in),
    .back_any_i  (back_in),
    .vals_i      (vals),
    .ctl_o       (ctl),
    .res_valid_o (m_axis_tvalid_o),
    .res_ready_i (m_axis_tready_i),
    .res_o       (res)
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign front_in[i] = (i == 0) ? 1'b0 : front_out[(i == 0) ? 0 : i - 1];
    assign back_in[i]  = (i == CAPACITY - 1) ? 1'b0 : back_out[(i == CAPACITY - 1) ? i : i + 1];

    olist_cell u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl),
      .idx_i       (IDX_W'(i)),
      .left_val_i  ((i == 0) ? vals[0] : vals[(i == 0) ? 0 : i - 1]),
      .right_val_i ((i == CAPACITY - 1) ? vals[i] : vals[(i == CAPACITY - 1) ? i : i + 1]),
      .front_any_i (front_in[i]),
      .back_any_i  (back_in[i]),
      .val_o       (vals[i]),
      .match_o     (match[i]),
      .front_any_o (front_out[i]),
      .back_any_o  (back_out[i])
    );
  end

  assign m_axis_tdata_o = M_TDATA_W'({res.value, res.length, res.found_pos});
  assign m_axis_tuser_o = res.status;
  assign m_axis_tlast_o = res.last;

endmodule

`default_nettype wire

// ===== rtl/core/olist_checker.sv =====
// ----------------------------------------------------------------------------
// olist_checker
// Port-level checks of the ordered list engine, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module olist_checker (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             m_axis_tvalid_o,
  input  wire logic                             m_axis_tready_i,
  input  wire logic [olist_pkg::M_TDATA_W-1:0]  m_axis_tdata_o,
  input  wire logic [olist_pkg::STAT_W-1:0]     m_axis_tuser_o,
  input  wire logic                             m_axis_tlast_o
);
  import olist_pkg::*;

  logic [POS_W-1:0] found_pos, length;

  assign found_pos = m_axis_tdata_o[POS_W-1:0];
  assign length    = m_axis_tdata_o[2*POS_W-1:POS_W];

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result transfer dropped while stalled");

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> length <= POS_W'(CAPACITY))
    else $error("length beyond capacity");

  a_full_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == STAT_FULL |-> length == POS_W'(CAPACITY))
    else $error("full status on a list that is not full");

  a_miss_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == STAT_MISS |-> found_pos == '0 && m_axis_tlast_o)
    else $error("refused request with a position or without last");

  a_pos_in_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == STAT_OK |-> found_pos <= length + POS_W'(1))
    else $error("position beyond list");

endmodule

bind ordered_list_engine olist_checker u_olist_checker (.*);

`default_nettype wire
